// ----- rtl/jpd_pkg.sv -----
// Shared types, constants and register codes of the junction pixel detector.
package jpd_pkg;

   // Default frame limits handed to the top level parameters.
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Field widths of the channels.
   localparam int COMP_W   = 8;
   localparam int PIX_W    = 3 * COMP_W;
   localparam int CSR_IDX_W = 2;
   localparam int ROW_W    = 12;
   localparam int COL_W    = 11;
   localparam int VERTEX_W = 23;
   localparam int DIST_W   = 4;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;

   // Number of window neighbors and the junction threshold.
   localparam int NEIGHBOURS   = 8;
   localparam int JUNCTION_MIN = 3;
   localparam int MIN_SIZE     = 3;

   // Register reset values.
   localparam logic [PIX_W-1:0]        RST_BOUNDARY = '1;
   localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH    = CFG_WIDTH_W'(2048);
   localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT   = CFG_HEIGHT_W'(4096);

   typedef logic [PIX_W-1:0] pixel_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOUNDARY_COLOR = 2'd0,
      CSR_IMAGE_WIDTH    = 2'd1,
      CSR_IMAGE_HEIGHT   = 2'd2
   } csr_index_type;

endpackage

// ----- rtl/jpd_req_if.sv -----
// Channel interfaces of the junction pixel detector: pixels, results and register writes.
interface jpd_req_if;
   logic                        valid;
   logic                        ready;
   logic [jpd_pkg::COMP_W-1:0]  red;
   logic [jpd_pkg::COMP_W-1:0]  green;
   logic [jpd_pkg::COMP_W-1:0]  blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface jpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [jpd_pkg::ROW_W-1:0]     row;
   logic [jpd_pkg::COL_W-1:0]     column;
   logic                          is_boundary;
   logic                          is_junction;
   logic [jpd_pkg::VERTEX_W-1:0]  vertex_number;
   logic [jpd_pkg::DIST_W-1:0]    distinct_neighbours;

   modport source (output valid, output row, output column, output is_boundary,
                   output is_junction, output vertex_number, output distinct_neighbours,
                   input ready);
   modport sink   (input valid, input row, input column, input is_boundary,
                   input is_junction, input vertex_number, input distinct_neighbours,
                   output ready);
endinterface

interface jpd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [jpd_pkg::CSR_IDX_W-1:0]  index;
   logic [jpd_pkg::PIX_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/junction_pixel_detector_core.sv -----
// Top level of the junction pixel detector: line stores, 3x3 window and classification.
//
// The block takes one raster pixel per cycle unless the result channel stalls it and returns
// one result per interior pixel. The synchronous read of the two line stores is registered
// on acceptance, the window update and the pairwise color compares when the pixel leaves
// stage one, and the neighbor count in the output register. The line stores are single
// memories of MAX_WIDTH entries; a fill count marks which columns have been written since
// reset, so unwritten entries read as zero and no clearing pass is needed after reset. Each
// store is read and written once per pixel, which sets the one pixel per cycle rate. Border
// rows and columns advance the window but produce no result. Register writes are always
// taken and must only occur while the pipeline is empty.
module junction_pixel_detector_core #(
   parameter int MAX_WIDTH  = jpd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = jpd_pkg::DEF_MAX_HEIGHT
) (
   input logic clock,
   input logic reset,
   jpd_req_if.sink   req_ch,
   jpd_rsp_if.source rsp_ch,
   jpd_csr_if.sink   csr_ch
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int WCMP = (CW + 1 > jpd_pkg::CFG_WIDTH_W) ? CW + 1 : jpd_pkg::CFG_WIDTH_W;
   localparam int HCMP = (RW + 1 > jpd_pkg::CFG_HEIGHT_W) ? RW + 1 : jpd_pkg::CFG_HEIGHT_W;
   localparam logic [WCMP-1:0] W_MAX = WCMP'(MAX_WIDTH);
   localparam logic [WCMP-1:0] W_MIN = WCMP'(jpd_pkg::MIN_SIZE);
   localparam logic [HCMP-1:0] H_MAX = HCMP'(MAX_HEIGHT);
   localparam logic [HCMP-1:0] H_MIN = HCMP'(jpd_pkg::MIN_SIZE);
   localparam logic [CW:0]     FILL_MAX = (CW + 1)'(MAX_WIDTH);

   typedef struct packed {
      jpd_pkg::pixel_type pix;
      logic [CW-1:0]      col;
      logic [RW-1:0]      row;
      logic               fill_ok;
      logic               produce;
      logic               frame_end;
   } stage1_type;

   typedef struct packed {
      logic [jpd_pkg::ROW_W-1:0]      row;
      logic [jpd_pkg::COL_W-1:0]      column;
      logic                           bnd;
      logic [jpd_pkg::VERTEX_W-1:0]   vnum;
      logic [jpd_pkg::NEIGHBOURS-1:0] keep;
   } stage2_type;

   // Configuration registers.
   jpd_pkg::pixel_type                  boundary_ff;
   logic [jpd_pkg::CFG_WIDTH_W-1:0]     width_ff;
   logic [jpd_pkg::CFG_HEIGHT_W-1:0]    height_ff;

   // Raster position, fill count and vertex counter.
   logic [CW-1:0]                col_ff, col_in;
   logic [RW-1:0]                row_ff, row_in;
   logic [CW:0]                  fill_ff, fill_in;
   logic [jpd_pkg::VERTEX_W-1:0] vertex_ff, vertex_in;

   // Line stores and their registered read data.
   jpd_pkg::pixel_type mem_upper  [MAX_WIDTH];
   jpd_pkg::pixel_type mem_middle [MAX_WIDTH];
   jpd_pkg::pixel_type upper_rd_ff, middle_rd_ff;

   // Window columns left of the incoming one.
   jpd_pkg::pixel_type win_ff [6];

   // Pipeline stages.
   stage1_type s1_ff, s1_in;
   logic       s1_valid_ff;
   stage2_type s2_ff, s2_in;
   logic       s2_valid_ff;

   // Output register.
   logic                           rsp_valid_ff;
   logic [jpd_pkg::ROW_W-1:0]      rsp_row_ff;
   logic [jpd_pkg::COL_W-1:0]      rsp_column_ff;
   logic                           rsp_boundary_ff;
   logic                           rsp_junction_ff;
   logic [jpd_pkg::VERTEX_W-1:0]   rsp_vertex_ff;
   logic [jpd_pkg::DIST_W-1:0]     rsp_dist_ff;

   // Stage enables and handshake.
   logic en_a, en_b, en_c, accept, s1_move;

   logic [WCMP-1:0] wid_ext, wid_eff, col_next;
   logic [HCMP-1:0] hgt_ext, hgt_eff, row_next;
   logic            last_col, last_row;

   jpd_pkg::pixel_type ntop, nmid, nbot;
   jpd_pkg::pixel_type nb [jpd_pkg::NEIGHBOURS];
   logic [jpd_pkg::NEIGHBOURS-1:0] keep;
   logic                           centre_bnd;
   logic [jpd_pkg::DIST_W-1:0]     count;
   logic [jpd_pkg::DIST_W-1:0]     dist_cnt;

   // Each stage advances when it is empty or its successor advances.
   assign en_c    = !rsp_valid_ff || rsp_ch.ready;
   assign en_b    = !s2_valid_ff || en_c;
   assign en_a    = !s1_valid_ff || en_b;
   assign accept  = req_ch.valid && en_a;
   assign s1_move = s1_valid_ff && en_b;

   assign req_ch.ready = en_a;
   assign csr_ch.ready = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= jpd_pkg::RST_BOUNDARY;
         width_ff    <= jpd_pkg::RST_WIDTH;
         height_ff   <= jpd_pkg::RST_HEIGHT;
      end else if (csr_ch.valid) begin
         unique case (jpd_pkg::csr_index_type'(csr_ch.index))
            jpd_pkg::CSR_BOUNDARY_COLOR: boundary_ff <= csr_ch.data;
            jpd_pkg::CSR_IMAGE_WIDTH:    width_ff    <= csr_ch.data[jpd_pkg::CFG_WIDTH_W-1:0];
            jpd_pkg::CSR_IMAGE_HEIGHT:   height_ff   <= csr_ch.data[jpd_pkg::CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size, clamped to the supported range.
   always_comb begin
      wid_ext = WCMP'(width_ff);
      hgt_ext = HCMP'(height_ff);
      priority if (wid_ext < W_MIN) wid_eff = W_MIN;
      else if (wid_ext > W_MAX)     wid_eff = W_MAX;
      else                          wid_eff = wid_ext;
      priority if (hgt_ext < H_MIN) hgt_eff = H_MIN;
      else if (hgt_ext > H_MAX)     hgt_eff = H_MAX;
      else                          hgt_eff = hgt_ext;
   end

   // Raster counters and the fill count of the line stores.
   always_comb begin
      col_next = WCMP'(col_ff) + WCMP'(1);
      row_next = HCMP'(row_ff) + HCMP'(1);
      last_col = col_next >= wid_eff;
      last_row = row_next >= hgt_eff;
      col_in   = last_col ? '0 : col_next[CW-1:0];
      if (last_col) begin
         row_in = last_row ? '0 : row_next[RW-1:0];
      end else begin
         row_in = row_ff;
      end
      fill_in = ((CW + 1)'(col_ff) < fill_ff) ? fill_ff : (CW + 1)'(col_ff) + (CW + 1)'(1);

      s1_in.pix       = {req_ch.blue, req_ch.green, req_ch.red};
      s1_in.col       = col_ff;
      s1_in.row       = row_ff;
      s1_in.fill_ok   = (CW + 1)'(col_ff) < fill_ff;
      s1_in.produce   = (row_ff >= RW'(2)) && (col_ff >= CW'(2));
      s1_in.frame_end = last_col && last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         fill_ff <= fill_in;
      end
   end

   // Line store read on acceptance, write back when the pixel leaves stage one.
   always_ff @(posedge clock) begin
      if (accept) begin
         upper_rd_ff  <= mem_upper[col_ff];
         middle_rd_ff <= mem_middle[col_ff];
      end
      if (s1_move) begin
         mem_upper[s1_ff.col]  <= nmid;
         mem_middle[s1_ff.col] <= nbot;
      end
   end

   // Stage one register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en_a) begin
         s1_valid_ff <= req_ch.valid;
      end
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // Neighbors of the window center and the first-occurrence compares.
   always_comb begin
      ntop = s1_ff.fill_ok ? upper_rd_ff  : '0;
      nmid = s1_ff.fill_ok ? middle_rd_ff : '0;
      nbot = s1_ff.pix;
      nb[0] = win_ff[1];
      nb[1] = nmid;
      nb[2] = win_ff[0];
      nb[3] = ntop;
      nb[4] = win_ff[2];
      nb[5] = nbot;
      nb[6] = win_ff[3];
      nb[7] = win_ff[5];
      centre_bnd = win_ff[4] == boundary_ff;
      for (int k = 0; k < jpd_pkg::NEIGHBOURS; k++) begin
         keep[k] = nb[k] != boundary_ff;
         for (int m = 0; m < k; m++) begin
            if (nb[m] == nb[k]) begin
               keep[k] = 1'b0;
            end
         end
      end

      s2_in.row    = jpd_pkg::ROW_W'(s1_ff.row - RW'(1));
      s2_in.column = jpd_pkg::COL_W'(s1_ff.col - CW'(1));
      s2_in.bnd    = centre_bnd;
      s2_in.vnum   = centre_bnd ? vertex_ff : '0;
      s2_in.keep   = keep;

      if (s1_ff.frame_end) begin
         vertex_in = '0;
      end else if (s1_ff.produce && centre_bnd) begin
         vertex_in = vertex_ff + jpd_pkg::VERTEX_W'(1);
      end else begin
         vertex_in = vertex_ff;
      end
   end

   // Window shift and vertex counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_ff <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_move) begin
         vertex_ff <= vertex_in;
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= ntop;
         win_ff[4] <= nmid;
         win_ff[5] <= nbot;
      end
   end

   // Stage two register: only window centers that produce a result enter.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en_b) begin
         s2_valid_ff <= s1_valid_ff && s1_ff.produce;
      end
      if (en_b) begin
         s2_ff <= s2_in;
      end
   end

   // Count the distinct neighbor colors.
   always_comb begin
      count = '0;
      for (int k = 0; k < jpd_pkg::NEIGHBOURS; k++) begin
         count = count + jpd_pkg::DIST_W'(s2_ff.keep[k]);
      end
      dist_cnt = s2_ff.bnd ? count : '0;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_c) begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (en_c) begin
         rsp_row_ff      <= s2_ff.row;
         rsp_column_ff   <= s2_ff.column;
         rsp_boundary_ff <= s2_ff.bnd;
         rsp_junction_ff <= s2_ff.bnd && (dist_cnt >= jpd_pkg::DIST_W'(jpd_pkg::JUNCTION_MIN));
         rsp_vertex_ff   <= s2_ff.vnum;
         rsp_dist_ff     <= dist_cnt;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.row                 = rsp_row_ff;
   assign rsp_ch.column              = rsp_column_ff;
   assign rsp_ch.is_boundary         = rsp_boundary_ff;
   assign rsp_ch.is_junction         = rsp_junction_ff;
   assign rsp_ch.vertex_number       = rsp_vertex_ff;
   assign rsp_ch.distinct_neighbours = rsp_dist_ff;

`ifndef SYNTHESIS
   // A line store write never hits the column being read in the same cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (s1_move && accept) |-> (s1_ff.col != col_ff))
      else $error("line store read and write collide on one column");

   // The fill count never passes the store depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("line store fill count beyond depth");

   // A non-boundary center carries no vertex number, count or junction mark.
   a_nonboundary_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_boundary_ff) |->
         (rsp_dist_ff == '0 && rsp_vertex_ff == '0 && !rsp_junction_ff))
      else $error("non-boundary result carries boundary data");

   // Stage two fills only from a producing stage-one pixel in the cycle before.
   a_s2_source: assert property (@(posedge clock) disable iff (reset)
      $rose(s2_valid_ff) |-> $past(s1_valid_ff && s1_ff.produce))
      else $error("stage two filled without a producing pixel");
`endif

endmodule
